FILE: rtl/sfa_pkg.sv
`default_nettype none

package sfa_pkg;

    // Configuration register indexes
    localparam logic CFG_IDX_ENABLE = 1'b0;
    localparam logic CFG_IDX_MASK   = 1'b1;
    localparam int   CFG_IDX_W      = 1;
    localparam int   CFG_DATA_W     = 32;

    localparam logic [31:0] MASK_RESET = 32'h5354_554E;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [15:0] LEN_INCR   = 16'd8;

    // Fingerprint attribute header bytes
    localparam logic [7:0] FP_TYPE_HI = 8'h80;
    localparam logic [7:0] FP_TYPE_LO = 8'h28;
    localparam logic [7:0] FP_LEN_HI  = 8'h00;
    localparam logic [7:0] FP_LEN_LO  = 8'h04;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Command codes
    localparam logic [1:0] OP_ONE = 2'd0;
    localparam logic [1:0] OP_TWO = 2'd1;
    localparam logic [1:0] OP_FP  = 2'd2;

    // Byte index inside a fingerprint command: 0 is the body byte, 8 the last CRC byte
    localparam int SEQ_W = 4;
    localparam logic [SEQ_W-1:0] SEQ_FP_LAST = 4'd8;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        last;
        logic [31:0] fp;
    } t_cmd;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
        end
        return x;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sfa_in_if.sv
`default_nettype none

interface sfa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfa_out_if.sv
`default_nettype none

interface sfa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/stun_fingerprint_appender_top.sv
`default_nettype none
// STUN fingerprint appender.
// i_in carries the bytes of a serialized message, header first, last_byte on
// the final one; o_out carries the framed message with out_last on its final
// byte. Both are valid/ready channels; a byte moves on a transfer.
// With fingerprint_enable set when header byte 2 arrives, the body length in
// bytes 2 and 3 is raised by 8 and an 8-byte fingerprint attribute (type
// 0x8028, length 4, CRC-32 xor mask) follows the last byte. Otherwise, or if
// the message ends by byte 3, bytes pass unchanged.
// Config: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 enable,
// 1 xor mask); write only while no message is in flight.
// Throughput: one byte per cycle in and out while the queue has room and the
// receiver is ready. A fingerprinted message of n bytes leaves as n+8 bytes;
// with the receiver always ready the four-entry command queue takes part of
// that and input is held off after the last byte once the queue is full.
// The output sequencer, one byte per cycle while the receiver is ready, sets
// this. With fingerprinting on, header byte 2 is held and leaves with 3.
// Reset: synchronous, clears the queue, the output valid and the CRC;
// enable resets off, mask to 0x5354554E. A stalled receiver fills the queue
// and then drops i_in.ready; nothing is lost.

module stun_fingerprint_appender_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    sfa_in_if.sink                              i_in,
    sfa_out_if.source                           o_out
);

    logic          w_push, w_full, w_pop, w_avail;
    sfa_pkg::t_cmd w_cmd_in, w_cmd_head;

    sfa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .i_data      (i_in.data_byte),
        .i_last      (i_in.last_byte),
        .o_ready     (i_in.ready),
        .o_push      (w_push),
        .o_cmd       (w_cmd_in),
        .i_full      (w_full)
    );

    sfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_head),
        .o_avail (w_avail)
    );

    sfa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_head),
        .i_avail (w_avail),
        .o_pop   (w_pop),
        .o_valid (o_out.valid),
        .o_byte  (o_out.out_byte),
        .o_last  (o_out.out_last),
        .i_ready (o_out.ready)
    );

endmodule

`default_nettype wire

FILE: rtl/sfa_front.sv
`default_nettype none

module sfa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                          i_valid,
    input  wire logic [7:0]                    i_data,
    input  wire logic                          i_last,
    output logic                               o_ready,
    output logic                               o_push,
    output sfa_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_full
);

    localparam logic [2:0] POS_B0    = 3'd0;
    localparam logic [2:0] POS_B1    = 3'd1;
    localparam logic [2:0] POS_B2    = 3'd2;
    localparam logic [2:0] POS_B3    = 3'd3;
    localparam logic [2:0] POS_BODY  = 3'd4;
    localparam logic [2:0] POS_B3_PT = 3'd5;
    localparam logic [2:0] POS_PT    = 3'd6;

    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_crc, n_crc;
    logic [7:0]  r_held, n_held;
    logic        r_en;
    logic [31:0] r_mask;
    logic        w_acc;
    logic [15:0] w_len;
    logic [31:0] w_crc_b;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;
    assign w_len   = {r_held, i_data} + sfa_pkg::LEN_INCR;
    assign w_crc_b = sfa_pkg::crc_byte(r_crc, i_data);

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_held  = r_held;
        o_push  = 1'b0;
        o_cmd   = '{op: sfa_pkg::OP_ONE, b0: i_data, b1: i_data, last: i_last, fp: '0};
        if (w_acc) begin
            case (r_pos)
                POS_B0, POS_B1: begin
                    o_push = 1'b1;
                    n_crc  = w_crc_b;
                    n_pos  = r_pos + 3'd1;
                end
                POS_B2: begin
                    if (i_last || !r_en) begin
                        o_push = 1'b1;
                        n_crc  = w_crc_b;
                        n_pos  = POS_B3_PT;
                    end else begin
                        n_held = i_data;
                        n_pos  = POS_B3;
                    end
                end
                POS_B3: begin
                    o_push   = 1'b1;
                    o_cmd.op = sfa_pkg::OP_TWO;
                    if (i_last) begin
                        o_cmd.b0 = r_held;
                        o_cmd.b1 = i_data;
                    end else begin
                        o_cmd.b0 = w_len[15:8];
                        o_cmd.b1 = w_len[7:0];
                        n_pos    = POS_BODY;
                    end
                    n_crc = sfa_pkg::crc_byte(sfa_pkg::crc_byte(r_crc, o_cmd.b0), o_cmd.b1);
                end
                POS_BODY: begin
                    o_push = 1'b1;
                    n_crc  = w_crc_b;
                    if (i_last) begin
                        o_cmd.op = sfa_pkg::OP_FP;
                        o_cmd.fp = ~w_crc_b ^ r_mask;
                    end
                end
                default: begin
                    o_push = 1'b1;
                    n_crc  = w_crc_b;
                    n_pos  = POS_PT;
                end
            endcase
            // Message done: rearm for the next header
            if (i_last) begin
                n_crc = sfa_pkg::CRC_INIT;
                n_pos = POS_B0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_B0;
            r_crc  <= sfa_pkg::CRC_INIT;
            r_held <= '0;
            r_en   <= 1'b0;
            r_mask <= sfa_pkg::MASK_RESET;
        end else begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_held <= n_held;
            if (i_cfg_we && i_cfg_idx == sfa_pkg::CFG_IDX_ENABLE) begin
                r_en <= i_cfg_wdata[0];
            end
            if (i_cfg_we && i_cfg_idx == sfa_pkg::CFG_IDX_MASK) begin
                r_mask <= i_cfg_wdata[31:0];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfa_queue.sv
`default_nettype none

module sfa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  sfa_pkg::t_cmd      i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output sfa_pkg::t_cmd      o_cmd,
    output logic               o_avail
);

    sfa_pkg::t_cmd                 r_mem [sfa_pkg::QDEPTH];
    logic [sfa_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [sfa_pkg::QCNT_W-1:0]    r_cnt, n_cnt;
    logic                          w_wr, w_rd;

    assign o_full  = (r_cnt == sfa_pkg::QCNT_W'(sfa_pkg::QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_avail;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfa_back.sv
`default_nettype none

module sfa_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  sfa_pkg::t_cmd i_cmd,
    input  wire logic     i_avail,
    output logic          o_pop,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_last,
    input  wire logic     i_ready
);

    logic [sfa_pkg::SEQ_W-1:0] r_seq;
    logic                      r_valid;
    logic [7:0]                r_byte;
    logic                      r_last;
    logic [7:0]                w_byte;
    logic                      w_last;
    logic                      w_final;
    logic                      w_load;

    // Pick the byte of the head command at the current sequence step
    always_comb begin
        w_byte  = i_cmd.b0;
        w_last  = i_cmd.last;
        w_final = 1'b1;
        case (i_cmd.op)
            sfa_pkg::OP_TWO: begin
                if (r_seq == '0) begin
                    w_last  = 1'b0;
                    w_final = 1'b0;
                end else begin
                    w_byte = i_cmd.b1;
                end
            end
            sfa_pkg::OP_FP: begin
                w_last  = (r_seq == sfa_pkg::SEQ_FP_LAST);
                w_final = w_last;
                case (r_seq)
                    4'd0:    w_byte = i_cmd.b0;
                    4'd1:    w_byte = sfa_pkg::FP_TYPE_HI;
                    4'd2:    w_byte = sfa_pkg::FP_TYPE_LO;
                    4'd3:    w_byte = sfa_pkg::FP_LEN_HI;
                    4'd4:    w_byte = sfa_pkg::FP_LEN_LO;
                    4'd5:    w_byte = i_cmd.fp[31:24];
                    4'd6:    w_byte = i_cmd.fp[23:16];
                    4'd7:    w_byte = i_cmd.fp[15:8];
                    default: w_byte = i_cmd.fp[7:0];
                endcase
            end
            default: begin
                w_byte = i_cmd.b0;
            end
        endcase
    end

    assign w_load  = i_avail && (!r_valid || i_ready);
    assign o_pop   = w_load && w_final;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seq   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_seq   <= w_final ? '0 : r_seq + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfa_checker.sv
`default_nettype none

module sfa_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_last,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic       i_out_last
);

    logic       w_in_end, w_out_end;
    logic [2:0] r_pend;

    assign w_in_end  = i_in_valid && i_in_ready && i_in_last;
    assign w_out_end = i_out_valid && i_out_ready && i_out_last;

    // Count messages taken in whose final byte has not yet left
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_in_end && !w_out_end) begin
            r_pend <= r_pend + 3'd1;
        end else if (w_out_end && !w_in_end) begin
            r_pend <= r_pend - 3'd1;
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_byte) && $stable(i_out_last))
        else $error("output payload changed while stalled");

    a_end_follows_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_end |-> (r_pend != 3'd0 || w_in_end))
        else $error("message end emitted with no message taken in");

endmodule

bind stun_fingerprint_appender_top sfa_checker u_sfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);

`default_nettype wire
